FILE: sv/shift_reduce_expr_parser_defines.svh
// Assertion macros for the checker of the expression parser.
// No dependencies; pulled in by `include.
`ifndef SHIFT_REDUCE_EXPR_PARSER_DEFINES_SVH
`define SHIFT_REDUCE_EXPR_PARSER_DEFINES_SVH

// Same-cycle implication, reset masks the check.
`define SREP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("expression parser check failed");

// Next-cycle implication, reset masks the check.
`define SREP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("expression parser check failed");

`endif

FILE: sv/srep_pkg.sv
// Types and constants of the shift-reduce expression parser.
// No dependencies; used by the top level and its checker.
package srep_pkg;

	localparam int unsigned STACK_DEPTH_DFLT = 64;
	localparam int unsigned SYM_W            = 8;
	localparam int unsigned DEPTH_W          = 7;

	localparam logic [SYM_W-1:0] SYM_I      = 8'h69;
	localparam logic [SYM_W-1:0] SYM_E      = 8'h45;
	localparam logic [SYM_W-1:0] SYM_PLUS   = 8'h2B;
	localparam logic [SYM_W-1:0] SYM_STAR   = 8'h2A;
	localparam logic [SYM_W-1:0] SYM_LPAREN = 8'h28;
	localparam logic [SYM_W-1:0] SYM_RPAREN = 8'h29;
	localparam logic [SYM_W-1:0] SYM_END    = 8'h24;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_FILL
	} srep_state_t;

endpackage

FILE: sv/shift_reduce_expr_parser.sv
// Shift-reduce expression parser: symbol stack in a synchronous RAM, top three cached.
// Depends on srep_pkg.
//
//  channel | signals                                 | dir | transaction
//  --------+-----------------------------------------+-----+-------------------------
//  in      | in_valid, in_ready, symbol, last        | in  | one symbol of the string
//  out     | out_valid, out_ready, depth, top_symbol,| out | one result per symbol
//          | finished, accepted, overflowed          |     |
//
// Sequence: each symbol is accepted (IDLE), then evaluated (EVAL); every three-entry
//   reduction (E+E, E*E, (E)) adds a FILL pass for the refill read of the stack RAM.
// Reset: arst_n clears the control state and count; the stack RAM needs no clear,
//   since only entries below the count are ever used.
// Stalls: a result waiting on out_ready holds the block in evaluation; a new
//   symbol is taken only once the previous one has been reduced and handed off.
module shift_reduce_expr_parser
	import srep_pkg::*;
#(
	parameter int unsigned STACK_DEPTH = STACK_DEPTH_DFLT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [SYM_W-1:0]   symbol,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [DEPTH_W-1:0] depth,
	output logic [SYM_W-1:0]   top_symbol,
	output logic               finished,
	output logic               accepted,
	output logic               overflowed
);

	localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

	// Stack RAM: one write port, two read ports with registered data.
	logic [SYM_W-1:0] stack_mem [STACK_DEPTH];
	logic [SYM_W-1:0] rd1_q, rd2_q;

	srep_state_t state_q, state_d;

	// Stack count and sticky per-string flags.
	logic [CW-1:0] count_q;
	logic          aborted_q;
	logic          overflow_q;
	logic          last_q;

	// Cached copy of the three top entries; only entries below count are meaningful.
	logic [SYM_W-1:0] top0_q, top1_q, top2_q;

	// Result register.
	logic               out_valid_q;
	logic [DEPTH_W-1:0] depth_q;
	logic [SYM_W-1:0]   top_symbol_q;
	logic               finished_q;
	logic               accepted_q;
	logic               overflowed_q;

	logic             in_fire;
	logic             is_end;
	logic             stack_full;
	logic             do_push;
	logic             do_ovf;
	logic             do_reduce;
	logic             do_fill;
	logic             load_out;
	logic             out_free;
	logic             binop_hit;
	logic             paren_hit;
	logic             red_hit;
	logic [SYM_W-1:0] push_sym;
	logic [CW-1:0]    cnt_m3, cnt_m4, cnt_m5;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [SYM_W-1:0] mem_wdata;

	assign in_fire    = in_valid && in_ready;
	assign is_end     = (symbol == SYM_END);
	assign stack_full = (count_q == CW'(STACK_DEPTH));
	// Frozen after an abort; '$' is never pushed.
	assign do_push    = in_fire && !aborted_q && !is_end && !stack_full;
	assign do_ovf     = in_fire && !aborted_q && !is_end && stack_full;
	// A pushed 'i' is reduced to 'E' at once, so 'i' never sits on the stack.
	assign push_sym   = (symbol == SYM_I) ? SYM_E : symbol;

	// The stack below the top is always fully reduced, so only the top three
	// entries can form a match.
	assign binop_hit = (top2_q == SYM_E) && ((top1_q == SYM_PLUS) || (top1_q == SYM_STAR))
		&& (top0_q == SYM_E);
	assign paren_hit = (top2_q == SYM_LPAREN) && (top1_q == SYM_E) && (top0_q == SYM_RPAREN);
	assign red_hit   = (count_q >= CW'(3)) && (binop_hit || paren_hit);

	assign out_free = !out_valid_q || out_ready;

	assign cnt_m3 = count_q - CW'(3);
	assign cnt_m4 = count_q - CW'(4);
	assign cnt_m5 = count_q - CW'(5);

	// RAM write: push at the count, or the collapsed 'E' at count-3.
	assign mem_we    = do_push || do_reduce;
	assign mem_waddr = do_push ? count_q[AW-1:0] : cnt_m3[AW-1:0];
	assign mem_wdata = do_push ? push_sym : SYM_E;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: EVAL tries one reduction per pass; a hit refills the two cached
	// entries under the new top from the RAM (FILL) and evaluates again.
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		do_reduce = 1'b0;
		do_fill   = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (red_hit) begin
					do_reduce = 1'b1;
					state_d   = ST_FILL;
				end else if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_FILL: begin
				do_fill = 1'b1;
				state_d = ST_EVAL;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Stack RAM. The reduce write (count-3) never meets the refill reads
	// (count-4, count-5), so no bypass is needed.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			stack_mem[mem_waddr] <= mem_wdata;
		end
		if (do_reduce) begin
			rd1_q <= stack_mem[cnt_m4[AW-1:0]];
			rd2_q <= stack_mem[cnt_m5[AW-1:0]];
		end
	end

	// Count and flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			aborted_q  <= 1'b0;
			overflow_q <= 1'b0;
			last_q     <= 1'b0;
		end else begin
			if (in_fire) begin
				last_q <= last;
				if (!aborted_q && is_end) begin
					aborted_q <= 1'b1;
				end
			end
			if (do_ovf) begin
				overflow_q <= 1'b1;
			end
			if (do_push) begin
				count_q <= count_q + CW'(1);
			end else if (do_reduce) begin
				count_q <= count_q - CW'(2);
			end else if (load_out && last_q) begin
				// end of string: start the next one clean
				count_q    <= '0;
				aborted_q  <= 1'b0;
				overflow_q <= 1'b0;
			end
		end
	end

	// Top-of-stack cache.
	always_ff @(posedge clk) begin
		if (do_push) begin
			top0_q <= push_sym;
			top1_q <= top0_q;
			top2_q <= top1_q;
		end else if (do_reduce) begin
			top0_q <= SYM_E;
		end else if (do_fill) begin
			top1_q <= rd1_q;
			top2_q <= rd2_q;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			depth_q      <= DEPTH_W'(count_q);
			top_symbol_q <= (count_q != '0) ? top0_q : '0;
			finished_q   <= last_q;
			// with one entry, the cached top is the bottom entry
			accepted_q   <= last_q && !aborted_q && !overflow_q
				&& (count_q == CW'(1)) && (top0_q == SYM_E);
			overflowed_q <= overflow_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign depth      = depth_q;
	assign top_symbol = top_symbol_q;
	assign finished   = finished_q;
	assign accepted   = accepted_q;
	assign overflowed = overflowed_q;

endmodule

FILE: sv/srep_checker.sv
// Port-level checker for the expression parser, bound to the top level.
// Depends on srep_pkg and shift_reduce_expr_parser_defines.svh.
`include "shift_reduce_expr_parser_defines.svh"

module srep_checker
	import srep_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic [SYM_W-1:0]   symbol,
	input logic               last,
	input logic               out_valid,
	input logic               out_ready,
	input logic [DEPTH_W-1:0] depth,
	input logic [SYM_W-1:0]   top_symbol,
	input logic               finished,
	input logic               accepted,
	input logic               overflowed
);

	// A stalled result holds.
	`SREP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(depth) && $stable(top_symbol) && $stable(accepted) && $stable(finished))

	// One symbol at a time: after a transaction in, the parser is busy.
	`SREP_ASSERT_NEXT(a_busy_after_in, clk, arst_n, in_valid && in_ready, !in_ready)

	// Acceptance means a finished string reduced to a single E, no overflow.
	`SREP_ASSERT_NOW(a_accept_shape, clk, arst_n, out_valid && accepted, finished && !overflowed && (depth == DEPTH_W'(1)) && (top_symbol == SYM_E))

	// An empty stack reports a zero top.
	`SREP_ASSERT_NOW(a_empty_top, clk, arst_n, out_valid && (depth == '0), top_symbol == '0)

endmodule

bind shift_reduce_expr_parser srep_checker u_srep_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.symbol     (symbol),
	.last       (last),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.depth      (depth),
	.top_symbol (top_symbol),
	.finished   (finished),
	.accepted   (accepted),
	.overflowed (overflowed)
);
